FILE: rtl/core/lcdr_pkg.sv
package lcdr_pkg;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_STEP   = 3'd1,
        CMD_DATA   = 3'd2,
        CMD_INSTR  = 3'd3,
        CMD_SELECT = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        PH_DONE  = 2'd0,
        PH_START = 2'd1,
        PH_RUN   = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        K_NONE,
        K_ARM,
        K_SELECT,
        K_STOP,
        K_HOME,
        K_CHAR,
        K_ADDR,
        K_DATA,
        K_INSTR
    } t_kind;

    typedef enum logic [2:0] {
        REG_RS_MASK  = 3'd0,
        REG_EN1_MASK = 3'd1,
        REG_EN2_MASK = 3'd2,
        REG_AUX_MASK = 3'd3,
        REG_AUX_ON   = 3'd4
    } t_reg;

    localparam logic [7:0] DDRAM_SET = 8'h80;
    localparam logic [6:0] ADDR_00   = 7'h00;
    localparam logic [6:0] ADDR_40   = 7'h40;
    localparam logic [6:0] ADDR_14   = 7'h14;
    localparam logic [6:0] ADDR_54   = 7'h54;

    localparam logic [3:0] RST_RS_MASK  = 4'd1;
    localparam logic [3:0] RST_EN1_MASK = 4'd2;
    localparam logic [3:0] RST_EN2_MASK = 4'd4;
    localparam logic [3:0] RST_AUX_MASK = 4'd8;
    localparam logic [1:0] ACT_BOTH     = 2'd3;
    localparam logic [1:0] ACT_FIRST    = 2'd1;
    localparam logic [1:0] ACT_SECOND   = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [3:0] rs_mask;
        logic [3:0] en1_mask;
        logic [3:0] en2_mask;
        logic [3:0] aux_mask;
        logic       aux_on;
    } t_cfg;

    typedef struct packed {
        logic [7:0] byte_val;
        logic [3:0] ctl;
        logic [3:0] en;
        logic       took;
        logic       done;
    } t_job;

endpackage

FILE: rtl/core/lcdr_front.sv
module lcdr_front #(
    parameter int LINE_COUNT = 2,
    parameter int LINE_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [2:0]       i_command,
    input  logic [7:0]       i_data_byte,
    input  lcdr_pkg::t_cfg   i_cfg,
    input  logic             i_job_full,
    output logic             o_job_push,
    output lcdr_pkg::t_job   o_job
);
    import lcdr_pkg::*;

    localparam bit         DUAL  = (LINE_COUNT == 4) && (LINE_WIDTH == 40);
    localparam bit         MULTI = (LINE_COUNT > 1);
    localparam bit         FOUR  = (LINE_COUNT == 4);
    localparam logic [5:0] COL_W = 6'(LINE_WIDTH);

    t_phase     r_phase, n_phase;
    logic [1:0] r_line, n_line;
    logic [5:0] r_col, n_col;
    logic [1:0] r_act, n_act;

    t_kind      w_kind;
    logic [6:0] w_addr;
    logic       w_accept;
    logic [3:0] w_en;
    logic [3:0] w_ctl;
    logic       w_is_data;
    logic       w_emit;
    logic [7:0] w_byte;

    assign o_full   = i_job_full;
    assign w_accept = i_push && !i_job_full;

    always_comb begin
        w_kind = K_NONE;
        w_addr = ADDR_00;
        unique case (t_cmd'(i_command))
            CMD_START:  w_kind = K_ARM;
            CMD_SELECT: w_kind = K_SELECT;
            CMD_DATA:   w_kind = K_DATA;
            CMD_INSTR:  w_kind = K_INSTR;
            CMD_STEP: begin
                priority if (r_phase == PH_START) begin
                    w_kind = K_HOME;
                end else if (r_phase != PH_RUN) begin
                    w_kind = K_STOP;
                end else if (r_col < COL_W) begin
                    w_kind = K_CHAR;
                end else if (r_col == COL_W) begin
                    priority if (r_line == 2'd0 && MULTI) begin
                        w_kind = K_ADDR;
                        w_addr = ADDR_40;
                    end else if (r_line == 2'd1 && FOUR) begin
                        w_kind = K_ADDR;
                        w_addr = DUAL ? ADDR_00 : ADDR_14;
                    end else if (r_line == 2'd2 && FOUR) begin
                        w_kind = K_ADDR;
                        w_addr = DUAL ? ADDR_40 : ADDR_54;
                    end else begin
                        w_kind = K_STOP;
                    end
                end else begin
                    w_kind = K_STOP;
                end
            end
            default: w_kind = K_NONE;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_line  = r_line;
        n_col   = r_col;
        n_act   = r_act;
        if (w_accept) begin
            unique case (w_kind)
                K_ARM:    n_phase = PH_START;
                K_SELECT: n_act   = i_data_byte[1:0];
                K_STOP:   n_phase = PH_DONE;
                K_HOME: begin
                    if (DUAL) begin
                        n_act = ACT_FIRST;
                    end
                    n_phase = PH_RUN;
                    n_line  = 2'd0;
                    n_col   = 6'd0;
                end
                K_CHAR: n_col = r_col + 6'd1;
                K_ADDR: begin
                    if (DUAL && r_line == 2'd1) begin
                        n_act = ACT_SECOND;
                    end
                    n_line = r_line + 2'd1;
                    n_col  = 6'd0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        w_emit    = 1'b0;
        w_is_data = 1'b0;
        w_byte    = i_data_byte;
        unique case (w_kind)
            K_HOME: begin
                w_emit = 1'b1;
                w_byte = DDRAM_SET;
            end
            K_ADDR: begin
                w_emit = 1'b1;
                w_byte = DDRAM_SET | {1'b0, w_addr};
            end
            K_CHAR, K_DATA: begin
                w_emit    = 1'b1;
                w_is_data = 1'b1;
            end
            K_INSTR: w_emit = 1'b1;
            default: ;
        endcase

        w_en = (n_act[0] ? i_cfg.en1_mask : 4'd0) | (n_act[1] ? i_cfg.en2_mask : 4'd0);
        w_ctl = i_cfg.aux_on ? (w_en | i_cfg.aux_mask) : (w_en & ~i_cfg.aux_mask);
        w_ctl = w_is_data ? (w_ctl | i_cfg.rs_mask) : (w_ctl & ~i_cfg.rs_mask);

        o_job_push     = w_accept && w_emit;
        o_job.byte_val = w_byte;
        o_job.ctl      = w_ctl;
        o_job.en       = w_en;
        o_job.took     = (w_kind == K_CHAR);
        o_job.done     = (n_phase == PH_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_line  <= 2'd0;
            r_col   <= 6'd0;
            r_act   <= ACT_BOTH;
        end else begin
            r_phase <= n_phase;
            r_line  <= n_line;
            r_col   <= n_col;
            r_act   <= n_act;
        end
    end

endmodule

FILE: rtl/core/lcdr_fifo.sv
module lcdr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lcdr_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output lcdr_pkg::t_job o_job
);
    import lcdr_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [AW:0]   DEPTH_C = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(QUEUE_DEPTH - 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW:0]   r_count;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == DEPTH_C);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == LAST_C) ? '0 : r_wptr + AW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == LAST_C) ? '0 : r_rptr + AW'(1);
            end
            r_count <= r_count + (AW + 1)'(w_push) - (AW + 1)'(w_pop);
        end
    end

endmodule

FILE: rtl/core/lcdr_back.sv
module lcdr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  lcdr_pkg::t_job i_job,
    output logic           o_job_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [7:0]     o_shift_word,
    output logic           o_last_word,
    output logic           o_char_taken,
    output logic           o_refresh_done
);
    import lcdr_pkg::*;

    t_job       r_job;
    logic [1:0] r_cnt;
    logic       r_busy;
    logic       r_ovalid;
    logic [7:0] r_word;
    logic       r_last;
    logic       r_took;
    logic       r_done;

    logic       w_advance;
    logic       w_have;
    t_job       w_src;
    logic [1:0] w_cnt;
    logic [3:0] w_hi;
    logic [3:0] w_lo;

    assign w_advance = !r_ovalid || i_pop;
    assign w_have    = r_busy || i_job_valid;
    assign w_src     = r_busy ? r_job : i_job;
    assign w_cnt     = r_busy ? r_cnt : 2'd0;
    assign o_job_pop = w_advance && !r_busy && i_job_valid;

    // high nibble first, each nibble raised then dropped
    assign w_hi = w_cnt[1] ? w_src.byte_val[3:0] : w_src.byte_val[7:4];
    assign w_lo = w_cnt[0] ? (w_src.ctl & ~w_src.en) : w_src.ctl;

    assign o_empty        = !r_ovalid;
    assign o_shift_word   = r_word;
    assign o_last_word    = r_last;
    assign o_char_taken   = r_took;
    assign o_refresh_done = r_done;

    always_ff @(posedge i_clk) begin
        if (w_advance && w_have) begin
            r_job  <= w_src;
            r_word <= {w_hi, w_lo};
            r_last <= (w_cnt == 2'd3);
            r_took <= w_src.took;
            r_done <= w_src.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= 2'd0;
            r_ovalid <= 1'b0;
        end else if (w_advance) begin
            r_ovalid <= w_have;
            if (w_have) begin
                r_cnt  <= w_cnt + 2'd1;
                r_busy <= (w_cnt != 2'd3);
            end
        end
    end

    a_idle_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt == 2'd0))
        else $error("beat counter left mid-byte while idle");

    a_busy_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_ovalid)
        else $error("byte in progress without a pending beat");

    a_last_ends_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_last) |-> !r_busy)
        else $error("final beat shown while byte still in progress");

endmodule

FILE: rtl/core/char_lcd_nibble_refresh_controller.sv
// Flow: an accepted item is written into the job queue; the back end then pops it and
// registers its first beat onto the result ports once it is idle and the port is not held.
// Output: an item that sends a byte gives four beats on the single result port, each
// held while pop is low; items sending nothing skip the queue. A 2-entry job queue parts them.
// Reset: synchronous, active low; clears the sequencer, queue and result valid flag and
// loads the register defaults.
module char_lcd_nibble_refresh_controller #(
    parameter int LINE_COUNT = 2,
    parameter int LINE_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_shift_word,
    output logic        o_last_word,
    output logic        o_char_taken,
    output logic        o_refresh_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcdr_pkg::*;

    t_cfg r_cfg;
    logic w_cfg_wr;
    logic w_job_push;
    t_job w_job_in;
    logic w_job_full;
    logic w_job_valid;
    t_job w_job_out;
    logic w_job_pop;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rs_mask  <= RST_RS_MASK;
            r_cfg.en1_mask <= RST_EN1_MASK;
            r_cfg.en2_mask <= RST_EN2_MASK;
            r_cfg.aux_mask <= RST_AUX_MASK;
            r_cfg.aux_on   <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (t_reg'(paddr[4:2]))
                REG_RS_MASK:  r_cfg.rs_mask  <= pwdata[3:0];
                REG_EN1_MASK: r_cfg.en1_mask <= pwdata[3:0];
                REG_EN2_MASK: r_cfg.en2_mask <= pwdata[3:0];
                REG_AUX_MASK: r_cfg.aux_mask <= pwdata[3:0];
                REG_AUX_ON:   r_cfg.aux_on   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[4:2]))
            REG_RS_MASK:  prdata = {28'd0, r_cfg.rs_mask};
            REG_EN1_MASK: prdata = {28'd0, r_cfg.en1_mask};
            REG_EN2_MASK: prdata = {28'd0, r_cfg.en2_mask};
            REG_AUX_MASK: prdata = {28'd0, r_cfg.aux_mask};
            REG_AUX_ON:   prdata = {31'd0, r_cfg.aux_on};
            default:      prdata = 32'd0;
        endcase
    end

    lcdr_front #(
        .LINE_COUNT (LINE_COUNT),
        .LINE_WIDTH (LINE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_cfg       (r_cfg),
        .i_job_full  (w_job_full),
        .o_job_push  (w_job_push),
        .o_job       (w_job_in)
    );

    lcdr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_valid (w_job_valid),
        .o_job   (w_job_out)
    );

    lcdr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_job_valid),
        .i_job          (w_job_out),
        .o_job_pop      (w_job_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_shift_word   (o_shift_word),
        .o_last_word    (o_last_word),
        .o_char_taken   (o_char_taken),
        .o_refresh_done (o_refresh_done)
    );

endmodule

FILE: verif/char_lcd_nibble_refresh_controller_tb.sv
`timescale 1ns / 1ps

module char_lcd_nibble_refresh_controller_tb;
    import lcdr_pkg::*;

    localparam int LINES = 2;
    localparam int COLS = 16;
    localparam bit DUAL = (LINES == 4) && (COLS == 40);
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 40;

    typedef struct packed {
        logic [7:0] word;
        logic       last;
        logic       took;
        logic       done;
    } t_bus_beat;

    class lcd_bus_model;
        t_cfg        cfg;
        t_phase      phase;
        logic [1:0]  line;
        logic [5:0]  column;
        logic [1:0]  active;
        t_bus_beat   pending_beats[$];
        int          errors;
        int          beats;

        function new();
            cfg.rs_mask  = RST_RS_MASK;
            cfg.en1_mask = RST_EN1_MASK;
            cfg.en2_mask = RST_EN2_MASK;
            cfg.aux_mask = RST_AUX_MASK;
            cfg.aux_on   = 1'b0;
            phase  = PH_DONE;
            line   = '0;
            column = '0;
            active = ACT_BOTH;
            errors = 0;
            beats  = 0;
        endfunction

        function void write_reg(t_reg r, logic [31:0] v);
            case (r)
                REG_RS_MASK:  cfg.rs_mask  = v[3:0];
                REG_EN1_MASK: cfg.en1_mask = v[3:0];
                REG_EN2_MASK: cfg.en2_mask = v[3:0];
                REG_AUX_MASK: cfg.aux_mask = v[3:0];
                REG_AUX_ON:   cfg.aux_on   = v[0];
                default: ;
            endcase
        endfunction

        function void take_item(logic [2:0] cmd, logic [7:0] b);
            logic [7:0] out_byte;
            logic [6:0] addr;
            logic [3:0] en;
            logic [3:0] ctl;
            logic [7:0] w[4];
            bit sends;
            bit is_data;
            bit took;
            t_bus_beat bt;
            out_byte = b;
            addr = ADDR_00;
            sends = 0;
            is_data = 0;
            took = 0;
            case (cmd)
                CMD_START: phase = PH_START;
                CMD_STEP: begin
                    if (phase == PH_START) begin
                        if (DUAL) active = ACT_FIRST;
                        phase = PH_RUN;
                        line = '0;
                        column = '0;
                        sends = 1;
                        out_byte = DDRAM_SET;
                    end else if (phase != PH_RUN) begin
                        phase = PH_DONE;
                    end else if (column < COLS) begin
                        column = column + 6'd1;
                        took = 1;
                        sends = 1;
                        is_data = 1;
                    end else if (column == COLS) begin
                        sends = 1;
                        if (line == 0 && LINES > 1) begin
                            addr = ADDR_40;
                        end else if (line == 1 && LINES == 4) begin
                            if (DUAL) begin
                                active = ACT_SECOND;
                                addr = ADDR_00;
                            end else begin
                                addr = ADDR_14;
                            end
                        end else if (line == 2 && LINES == 4) begin
                            addr = DUAL ? ADDR_40 : ADDR_54;
                        end else begin
                            phase = PH_DONE;
                            sends = 0;
                        end
                        if (sends) begin
                            line = line + 2'd1;
                            column = '0;
                            out_byte = DDRAM_SET | {1'b0, addr};
                        end
                    end else begin
                        phase = PH_DONE;
                    end
                end
                CMD_DATA: begin
                    sends = 1;
                    is_data = 1;
                end
                CMD_INSTR: sends = 1;
                CMD_SELECT: active = b[1:0];
                default: ;
            endcase
            if (!sends) return;
            en = (active[0] ? cfg.en1_mask : 4'h0) | (active[1] ? cfg.en2_mask : 4'h0);
            ctl = en;
            if (cfg.aux_on) ctl = ctl | cfg.aux_mask;
            else ctl = ctl & ~cfg.aux_mask;
            if (is_data) ctl = ctl | cfg.rs_mask;
            else ctl = ctl & ~cfg.rs_mask;
            w[0] = {out_byte[7:4], ctl};
            w[1] = w[0] & ~{4'h0, en};
            w[2] = {out_byte[3:0], ctl};
            w[3] = w[2] & ~{4'h0, en};
            for (int k = 0; k < 4; k++) begin
                bt.word = w[k];
                bt.last = (k == 3);
                bt.took = took;
                bt.done = (phase == PH_DONE);
                pending_beats.push_back(bt);
            end
        endfunction

        function void match_beat(logic [7:0] word, logic last, logic took, logic done);
            t_bus_beat want;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat word=%h last=%b took=%b done=%b",
                         $time, word, last, took, done);
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            beats++;
            if (word !== want.word) begin
                $display("%0t: shift_word expected %h actual %h", $time, want.word, word);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last_word expected %b actual %b", $time, want.last, last);
                errors++;
            end
            if (took !== want.took) begin
                $display("%0t: char_taken expected %b actual %b", $time, want.took, took);
                errors++;
            end
            if (done !== want.done) begin
                $display("%0t: refresh_done expected %b actual %b", $time, want.done, done);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [2:0]  i_command;
    logic [7:0]  i_data_byte;
    logic        empty;
    logic        pop;
    logic [7:0]  o_shift_word;
    logic        o_last_word;
    logic        o_char_taken;
    logic        o_refresh_done;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcd_bus_model board = new();
    bit gaps_on;
    int pop_hold;
    int items_sent;
    int cfg_writes;

    char_lcd_nibble_refresh_controller #(
        .LINE_COUNT(LINES),
        .LINE_WIDTH(COLS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_command(i_command),
        .i_data_byte(i_data_byte),
        .empty(empty),
        .pop(pop),
        .o_shift_word(o_shift_word),
        .o_last_word(o_last_word),
        .o_char_taken(o_char_taken),
        .o_refresh_done(o_refresh_done),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold = pop_hold - 1;
        end else begin
            pop <= 1'b1;
            if (gaps_on && $urandom_range(0, 3) == 0) pop_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            board.match_beat(o_shift_word, o_last_word, o_char_taken, o_refresh_done);
        end
    end

    task automatic send_item(logic [2:0] cmd, logic [7:0] b);
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_command <= cmd;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.take_item(cmd, b);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (board.pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(t_reg r, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.write_reg(r, v);
        cfg_writes++;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_cfg(logic [3:0] rs, logic [3:0] en1, logic [3:0] en2,
                            logic [3:0] aux, logic aux_on);
        reg_write(REG_RS_MASK, {28'h0, rs});
        reg_write(REG_EN1_MASK, {28'h0, en1});
        reg_write(REG_EN2_MASK, {28'h0, en2});
        reg_write(REG_AUX_MASK, {28'h0, aux});
        reg_write(REG_AUX_ON, {31'h0, aux_on});
    endtask

    task automatic send_noise();
        send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    task automatic run_refresh(int steps, bit noisy);
        send_item(CMD_START, 8'($urandom_range(0, 255)));
        for (int s = 0; s < steps; s++) begin
            if (noisy && $urandom_range(0, 11) == 0) send_noise();
            send_item(CMD_STEP, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int steps;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_command = CMD_START;
        i_data_byte = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gaps_on = 1'b1;
        pop_hold = 0;
        items_sent = 0;
        cfg_writes = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(CMD_STEP, 8'h41);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hFF);
        send_item(CMD_INSTR, 8'h00);
        send_item(CMD_INSTR, 8'hFF);
        send_item(CMD_SELECT, 8'h00);
        send_item(CMD_DATA, 8'hA5);
        send_item(CMD_SELECT, 8'h01);
        send_item(CMD_INSTR, 8'h5A);
        send_item(CMD_SELECT, 8'h02);
        send_item(CMD_DATA, 8'h3C);
        send_item(CMD_SELECT, 8'hFF);
        send_item(3'd5, 8'h12);
        send_item(3'd6, 8'hED);
        send_item(3'd7, 8'h80);
        send_item(CMD_START, 8'h00);
        send_item(CMD_START, 8'h55);
        send_item(CMD_STEP, 8'h00);
        send_item(CMD_STEP, 8'h00);
        send_item(CMD_STEP, 8'hFF);
        send_item(CMD_START, 8'h00);
        send_item(CMD_STEP, 8'h7E);
        send_item(CMD_STEP, 8'h81);
        drain();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: load_cfg(4'hF, 4'hF, 4'hF, 4'hF, 1'b1);
                1: load_cfg(4'h0, 4'h0, 4'h0, 4'h0, 1'b0);
                default: load_cfg(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                  1'($urandom_range(0, 1)));
            endcase
            gaps_on = (p != 1);
            while (items_sent < 23 + PHASE_ITEMS * (p + 1)) begin
                if ($urandom_range(0, 9) < 7) begin
                    steps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 34)
                                                        : $urandom_range(35, 37);
                    run_refresh(steps, $urandom_range(0, 1));
                end else begin
                    send_noise();
                end
            end
            drain();
        end

        gaps_on = 1'b1;
        repeat (20) @(posedge i_clk);
        $display("Sent %0d items in 6 settings with %0d register writes; %0d beats checked.",
                 items_sent, cfg_writes, board.beats);
        $display("Covered full and cut-short refreshes, byte writes, selects and idle gaps.");
        if (board.errors == 0 && board.pending_beats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("Timed out with %0d beats outstanding", board.pending_beats.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
